// ----- rtl/rsws_pkg.sv -----
`timescale 1ns / 1ps

package rsws_pkg;

  // Storage geometry
  localparam int STACK_DEPTH = 64;
  localparam int PTR_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

  // Field widths
  localparam int OP_W    = 3;
  localparam int ID_W    = 31;
  localparam int PRICE_W = 32;
  localparam int SER_W   = 32;
  localparam int STAT_W  = 2;
  localparam int DEPTH_W = 7;
  localparam int TOT_W   = 38;

  localparam logic [SER_W-1:0] SERIAL_RESET = SER_W'(500);

  // Operation codes
  localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
  localparam logic [OP_W-1:0] OP_POP    = 3'd1;
  localparam logic [OP_W-1:0] OP_PEEK   = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
  localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
  localparam logic [OP_W-1:0] OP_TOTALS = 3'd5;

  // Status codes
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd1;
  localparam logic [STAT_W-1:0] STAT_EMPTY    = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [SER_W-1:0]   serial;
    logic [ID_W-1:0]    ticket;
    logic [ID_W-1:0]    passenger;
    logic [ID_W-1:0]    train;
    logic [PRICE_W-1:0] price;
  } rec_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [ID_W-1:0]    ticket_key;
    logic [ID_W-1:0]    passenger;
    logic [ID_W-1:0]    train;
    logic [PRICE_W-1:0] price;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0]  status;
    rec_t               rec;
    logic [DEPTH_W-1:0] depth;
    logic [TOT_W-1:0]   total;
    logic [PRICE_W-1:0] highest;
    logic [PRICE_W-1:0] lowest;
    logic               last;
  } res_t;

  typedef struct packed {
    logic             wr_en;
    logic [PTR_W-1:0] wr_addr;
    rec_t             wr_rec;
    logic             rd_en;
    logic [PTR_W-1:0] rd_addr;
  } mem_req_t;

endpackage

// ----- rtl/rsws_if.sv -----
`timescale 1ns / 1ps

interface rsws_in_if import rsws_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [OP_W-1:0]    op;
  logic [ID_W-1:0]    ticket_key;
  logic [ID_W-1:0]    passenger_in;
  logic [ID_W-1:0]    train_in;
  logic [PRICE_W-1:0] price_in;

  modport source (output valid, op, ticket_key, passenger_in, train_in, price_in,
                  input ready);
  modport sink   (input valid, op, ticket_key, passenger_in, train_in, price_in,
                  output ready);
endinterface

interface rsws_out_if import rsws_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [SER_W-1:0]   serial_out;
  logic [ID_W-1:0]    ticket_out;
  logic [ID_W-1:0]    passenger_out;
  logic [ID_W-1:0]    train_out;
  logic [PRICE_W-1:0] price_out;
  logic [DEPTH_W-1:0] depth_out;
  logic [TOT_W-1:0]   total_out;
  logic [PRICE_W-1:0] highest_out;
  logic [PRICE_W-1:0] lowest_out;
  logic               last;

  modport source (output valid, status, serial_out, ticket_out, passenger_out, train_out,
                  price_out, depth_out, total_out, highest_out, lowest_out, last,
                  input ready);
  modport sink   (input valid, status, serial_out, ticket_out, passenger_out, train_out,
                  price_out, depth_out, total_out, highest_out, lowest_out, last,
                  output ready);
endinterface

// ----- rtl/rsws_mem.sv -----
`timescale 1ns / 1ps

module rsws_mem import rsws_pkg::*; (
  input  logic     clk,
  input  mem_req_t req,
  output rec_t     rd_rec
);

  rec_t mem_r [STACK_DEPTH];
  rec_t rd_rec_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_rec;
    end
  end

  // Read data holds until the next read
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_rec_r <= mem_r[req.rd_addr];
    end
  end

  assign rd_rec = rd_rec_r;

endmodule

// ----- rtl/rsws_ctrl.sv -----
`timescale 1ns / 1ps

module rsws_ctrl import rsws_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  cmd_t     cmd_in,
  input  logic     out_free,
  output logic     emit,
  output res_t     res,
  output mem_req_t req,
  input  rec_t     rd_rec
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  typedef enum logic [1:0] {
    FK_PLAIN,
    FK_REC,
    FK_TOT
  } fin_kind_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic [SER_W-1:0]   serial_r, serial_nxt;
  logic [OP_W-1:0]    op_r, op_nxt;
  logic [ID_W-1:0]    key_r, key_nxt;
  logic [PTR_W-1:0]   idx_r, idx_nxt;
  logic [PTR_W-1:0]   lim_r, lim_nxt;
  logic               more_r, more_nxt;
  logic               rdv_r, rdv_nxt;
  logic               pend_v_r, pend_v_nxt;
  rec_t               rec_r, rec_nxt;
  logic [STAT_W-1:0]  stat_r, stat_nxt;
  fin_kind_t          kind_r, kind_nxt;
  logic [TOT_W-1:0]   tot_r, tot_nxt;
  logic [PRICE_W-1:0] hi_r, hi_nxt;
  logic [PRICE_W-1:0] lo_r, lo_nxt;

  logic [PTR_W-1:0]   top_idx;
  logic               match;
  logic               flush;

  function automatic res_t rec_res(rec_t r, logic lst, logic [CNT_W-1:0] cnt);
    res_t o;
    o         = '0;
    o.status  = STAT_OK;
    o.rec     = r;
    o.depth   = DEPTH_W'(cnt);
    o.last    = lst;
    return o;
  endfunction

  assign top_idx = PTR_W'(cnt_r - CNT_W'(1));
  assign match   = (op_r != OP_SEARCH) || (rd_rec.ticket == key_r);
  // An earlier match waits in rec_r until a later one proves it is not the last
  assign flush   = rdv_r && (op_r == OP_SEARCH) && match && pend_v_r;

  always_comb begin
    state_nxt  = state_r;
    cnt_nxt    = cnt_r;
    serial_nxt = serial_r;
    op_nxt     = op_r;
    key_nxt    = key_r;
    idx_nxt    = idx_r;
    lim_nxt    = lim_r;
    more_nxt   = more_r;
    rdv_nxt    = rdv_r;
    pend_v_nxt = pend_v_r;
    rec_nxt    = rec_r;
    stat_nxt   = stat_r;
    kind_nxt   = kind_r;
    tot_nxt    = tot_r;
    hi_nxt     = hi_r;
    lo_nxt     = lo_r;
    in_ready   = (state_r == ST_IDLE);
    emit       = 1'b0;
    res        = '0;
    req        = '0;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          op_nxt     = cmd_in.op;
          key_nxt    = cmd_in.ticket_key;
          pend_v_nxt = 1'b0;
          tot_nxt    = '0;
          hi_nxt     = '0;
          lo_nxt     = '1;
          stat_nxt   = STAT_OK;
          kind_nxt   = FK_PLAIN;
          state_nxt  = ST_FIN;
          case (cmd_in.op)
            OP_PUSH: begin
              if (cnt_r >= CNT_W'(STACK_DEPTH)) begin
                stat_nxt = STAT_FULL;
              end else begin
                serial_nxt        = serial_r + SER_W'(1);
                rec_nxt.serial    = serial_nxt;
                rec_nxt.ticket    = cmd_in.ticket_key;
                rec_nxt.passenger = cmd_in.passenger;
                rec_nxt.train     = cmd_in.train;
                rec_nxt.price     = cmd_in.price;
                req.wr_en         = 1'b1;
                req.wr_addr       = PTR_W'(cnt_r);
                req.wr_rec        = rec_nxt;
                cnt_nxt           = cnt_r + CNT_W'(1);
                pend_v_nxt        = 1'b1;
                kind_nxt          = FK_REC;
              end
            end
            OP_POP, OP_PEEK, OP_SEARCH, OP_TOTALS: begin
              if (cnt_r == '0) begin
                stat_nxt = STAT_EMPTY;
              end else begin
                state_nxt = ST_SCAN;
                more_nxt  = 1'b1;
                rdv_nxt   = 1'b0;
                if (cmd_in.op == OP_TOTALS) begin
                  kind_nxt = FK_TOT;
                  idx_nxt  = '0;
                  lim_nxt  = top_idx;
                end else begin
                  kind_nxt = FK_REC;
                  idx_nxt  = top_idx;
                  lim_nxt  = (cmd_in.op == OP_SEARCH) ? '0 : top_idx;
                end
                if (cmd_in.op == OP_POP) begin
                  cnt_nxt = cnt_r - CNT_W'(1);
                end
              end
            end
            OP_CLEAR: begin
              cnt_nxt = '0;
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // Stall the scan while a flushed match cannot leave
        if (!flush || out_free) begin
          if (rdv_r) begin
            if (flush) begin
              emit = 1'b1;
              res  = rec_res(rec_r, 1'b0, cnt_r);
            end
            if (op_r == OP_TOTALS) begin
              tot_nxt = tot_r + TOT_W'(rd_rec.price);
              if (rd_rec.price > hi_r) hi_nxt = rd_rec.price;
              if (rd_rec.price < lo_r) lo_nxt = rd_rec.price;
            end else if (match) begin
              rec_nxt    = rd_rec;
              pend_v_nxt = 1'b1;
            end
          end
          if (more_r) begin
            req.rd_en   = 1'b1;
            req.rd_addr = idx_r;
            rdv_nxt     = 1'b1;
            more_nxt    = (idx_r != lim_r);
            idx_nxt     = (op_r == OP_TOTALS) ? idx_r + PTR_W'(1) : idx_r - PTR_W'(1);
          end else begin
            rdv_nxt   = 1'b0;
            state_nxt = ST_FIN;
          end
        end
      end

      ST_FIN: begin
        if (out_free) begin
          emit      = 1'b1;
          state_nxt = ST_IDLE;
          case (kind_r)
            FK_REC: begin
              if (pend_v_r) begin
                res = rec_res(rec_r, 1'b1, cnt_r);
              end else begin
                res.status = STAT_NOTFOUND;
                res.depth  = DEPTH_W'(cnt_r);
                res.last   = 1'b1;
              end
            end
            FK_TOT: begin
              res.status  = STAT_OK;
              res.depth   = DEPTH_W'(cnt_r);
              res.total   = tot_r;
              res.highest = hi_r;
              res.lowest  = lo_r;
              res.last    = 1'b1;
            end
            default: begin
              res.status = stat_r;
              res.depth  = DEPTH_W'(cnt_r);
              res.last   = 1'b1;
            end
          endcase
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      serial_r <= SERIAL_RESET;
      more_r   <= 1'b0;
      rdv_r    <= 1'b0;
      pend_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      serial_r <= serial_nxt;
      more_r   <= more_nxt;
      rdv_r    <= rdv_nxt;
      pend_v_r <= pend_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r   <= op_nxt;
    key_r  <= key_nxt;
    idx_r  <= idx_nxt;
    lim_r  <= lim_nxt;
    rec_r  <= rec_nxt;
    stat_r <= stat_nxt;
    kind_r <= kind_nxt;
    tot_r  <= tot_nxt;
    hi_r   <= hi_nxt;
    lo_r   <= lo_nxt;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result emitted into a full output register");

  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    req.wr_en |-> (state_r == ST_IDLE) && (cnt_r < CNT_W'(STACK_DEPTH)))
    else $error("memory write outside an accepted push");

  a_fin_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) && out_free |=> (state_r == ST_IDLE))
    else $error("final result did not return to idle");

endmodule

// ----- rtl/record_stack_with_search.sv -----
`timescale 1ns / 1ps

// Channel   Modport  Transaction
// in_ch     sink     op, ticket_key, passenger_in, train_in, price_in
// out_ch    source   status, record fields, depth_out, totals, last
//
// Push, clear, unused codes and empty/full errors: no memory read.
// Pop and peek: one memory read. Search and totals: every entry is read,
// one entry read per cycle from the record memory;
// search holds its scan while a matched record cannot enter the output register.
// Reset (synchronous, rst_n low) empties the stack and loads the serial to 500;
// the record memory is not cleared and needs no clearing pass.
// A result waits in the output register while the next transaction is taken.

module record_stack_with_search import rsws_pkg::*; (
  input logic       clk,
  input logic       rst_n,
  rsws_in_if.sink   in_ch,
  rsws_out_if.source out_ch
);

  cmd_t     cmd;
  logic     in_ready;
  logic     emit;
  res_t     res;
  mem_req_t req;
  rec_t     rd_rec;
  logic     out_free;

  logic     out_valid_r, out_valid_nxt;
  res_t     out_res_r;

  // Pack the incoming transaction
  assign cmd.op         = in_ch.op;
  assign cmd.ticket_key = in_ch.ticket_key;
  assign cmd.passenger  = in_ch.passenger_in;
  assign cmd.train      = in_ch.train_in;
  assign cmd.price      = in_ch.price_in;
  assign in_ch.ready    = in_ready;

  rsws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd_in   (cmd),
    .out_free (out_free),
    .emit     (emit),
    .res      (res),
    .req      (req),
    .rd_rec   (rd_rec)
  );

  rsws_mem u_mem (
    .clk    (clk),
    .req    (req),
    .rd_rec (rd_rec)
  );

  // Output register: free when empty or being drained this cycle
  assign out_free = !out_valid_r || out_ch.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the payload until a new result replaces it
  always_ff @(posedge clk) begin
    if (emit) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_res_r.status;
  assign out_ch.serial_out    = out_res_r.rec.serial;
  assign out_ch.ticket_out    = out_res_r.rec.ticket;
  assign out_ch.passenger_out = out_res_r.rec.passenger;
  assign out_ch.train_out     = out_res_r.rec.train;
  assign out_ch.price_out     = out_res_r.rec.price;
  assign out_ch.depth_out     = out_res_r.depth;
  assign out_ch.total_out     = out_res_r.total;
  assign out_ch.highest_out   = out_res_r.highest;
  assign out_ch.lowest_out    = out_res_r.lowest;
  assign out_ch.last          = out_res_r.last;

endmodule

// ----- tb/record_stack_checker.sv -----
`timescale 1ns / 1ps

module record_stack_checker import rsws_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  rsws_in_if   in_ch,
  rsws_out_if  out_ch,
  output int   fail_count,
  output int   outstanding
);

  // Shadow copy of the record stack and the serial generator
  rec_t             shadow_stack [STACK_DEPTH];
  int unsigned      shadow_count;
  logic [SER_W-1:0] last_serial;
  res_t             pending_results [$];

  function automatic res_t status_only(logic [STAT_W-1:0] st);
    res_t r;
    r = '0;
    r.status = st;
    r.depth  = DEPTH_W'(shadow_count);
    r.last   = 1'b1;
    return r;
  endfunction

  function automatic res_t record_reply(int unsigned idx, logic is_last);
    res_t r;
    r = status_only(STAT_OK);
    r.rec  = shadow_stack[PTR_W'(idx)];
    r.last = is_last;
    return r;
  endfunction

  function automatic void predict_results(cmd_t c);
    res_t               r;
    int                 i;
    int unsigned        top_idx;
    int unsigned        hits;
    logic [TOT_W-1:0]   sum;
    logic [PRICE_W-1:0] hi;
    logic [PRICE_W-1:0] lo;
    case (c.op)
      OP_PUSH: begin
        if (shadow_count >= STACK_DEPTH) begin
          pending_results.push_back(status_only(STAT_FULL));
        end else begin
          last_serial = last_serial + SER_W'(1);
          shadow_stack[PTR_W'(shadow_count)] = '{serial: last_serial, ticket: c.ticket_key,
                                                 passenger: c.passenger, train: c.train,
                                                 price: c.price};
          shadow_count++;
          pending_results.push_back(record_reply(shadow_count - 1, 1'b1));
        end
      end
      OP_POP, OP_PEEK: begin
        if (shadow_count == 0) begin
          pending_results.push_back(status_only(STAT_EMPTY));
        end else begin
          top_idx = shadow_count - 1;
          if (c.op == OP_POP) shadow_count = top_idx;
          pending_results.push_back(record_reply(top_idx, 1'b1));
        end
      end
      OP_SEARCH: begin
        if (shadow_count == 0) begin
          pending_results.push_back(status_only(STAT_EMPTY));
        end else begin
          hits = 0;
          // scan from the top down
          for (i = int'(shadow_count) - 1; i >= 0; i--) begin
            if (shadow_stack[PTR_W'(i)].ticket == c.ticket_key) begin
              pending_results.push_back(record_reply(i, 1'b0));
              hits++;
            end
          end
          if (hits == 0) begin
            pending_results.push_back(status_only(STAT_NOTFOUND));
          end else begin
            r = pending_results.pop_back();
            r.last = 1'b1;
            pending_results.push_back(r);
          end
        end
      end
      OP_CLEAR: begin
        shadow_count = 0;
        pending_results.push_back(status_only(STAT_OK));
      end
      OP_TOTALS: begin
        if (shadow_count == 0) begin
          pending_results.push_back(status_only(STAT_EMPTY));
        end else begin
          sum = '0;
          hi  = '0;
          lo  = shadow_stack[PTR_W'(0)].price;
          for (i = 0; i < int'(shadow_count); i++) begin
            sum = sum + TOT_W'(shadow_stack[PTR_W'(i)].price);
            if (shadow_stack[PTR_W'(i)].price > hi) hi = shadow_stack[PTR_W'(i)].price;
            if (shadow_stack[PTR_W'(i)].price < lo) lo = shadow_stack[PTR_W'(i)].price;
          end
          r = status_only(STAT_OK);
          r.total   = sum;
          r.highest = hi;
          r.lowest  = lo;
          pending_results.push_back(r);
        end
      end
      default: begin
        pending_results.push_back(status_only(STAT_OK));
      end
    endcase
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      fail_count++;
      $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin
    cmd_t cmd;
    res_t got;
    res_t want;
    if (!rst_n) begin
      shadow_count = 0;
      last_serial  = SERIAL_RESET;
      pending_results.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        cmd = '{op: in_ch.op, ticket_key: in_ch.ticket_key, passenger: in_ch.passenger_in,
                train: in_ch.train_in, price: in_ch.price_in};
        predict_results(cmd);
      end
      if (out_ch.valid && out_ch.ready) begin
        got.status        = out_ch.status;
        got.rec.serial    = out_ch.serial_out;
        got.rec.ticket    = out_ch.ticket_out;
        got.rec.passenger = out_ch.passenger_out;
        got.rec.train     = out_ch.train_out;
        got.rec.price     = out_ch.price_out;
        got.depth         = out_ch.depth_out;
        got.total         = out_ch.total_out;
        got.highest       = out_ch.highest_out;
        got.lowest        = out_ch.lowest_out;
        got.last          = out_ch.last;
        if (pending_results.size() == 0) begin
          fail_count++;
          $display("%0t: result with none expected, actual status %0d serial %0d depth %0d last %0b",
                   $time, got.status, got.rec.serial, got.depth, got.last);
        end else begin
          want = pending_results.pop_front();
          compare_field("status",        64'(want.status),        64'(got.status));
          compare_field("serial_out",    64'(want.rec.serial),    64'(got.rec.serial));
          compare_field("ticket_out",    64'(want.rec.ticket),    64'(got.rec.ticket));
          compare_field("passenger_out", 64'(want.rec.passenger), 64'(got.rec.passenger));
          compare_field("train_out",     64'(want.rec.train),     64'(got.rec.train));
          compare_field("price_out",     64'(want.rec.price),     64'(got.rec.price));
          compare_field("depth_out",     64'(want.depth),         64'(got.depth));
          compare_field("total_out",     64'(want.total),         64'(got.total));
          compare_field("highest_out",   64'(want.highest),       64'(got.highest));
          compare_field("lowest_out",    64'(want.lowest),        64'(got.lowest));
          compare_field("last",          64'(want.last),          64'(got.last));
        end
      end
    end
    outstanding <= pending_results.size();
  end

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;
  import rsws_pkg::*;

  // The two op codes the block leaves unused; it answers them with a bare status
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  localparam logic [ID_W-1:0]    ID_MAX    = {ID_W{1'b1}};
  localparam logic [PRICE_W-1:0] PRICE_MAX = {PRICE_W{1'b1}};

  localparam int RANDOM_ITEMS = 270;
  localparam int FILL_AT      = 90;     // random transaction index where the stack gets filled
  localparam int HOLD_CYCLES  = 300;    // receiver hold-off while the stack is being filled
  localparam int DRAIN_CYCLES = 80;     // idle wait after the last result
  localparam int CYCLE_LIMIT  = 400000;

  logic clk;
  logic rst_n;

  rsws_in_if  in_ch ();
  rsws_out_if out_ch ();

  int fail_count;
  int outstanding;

  // Sender-side state
  bit               steady_in;    // no sender gaps while set
  bit               hold_req;     // asks the receiver for its long hold-off
  logic [ID_W-1:0]  key_pool [4]; // small key set so that searches find records
  int               rand_sent;

  record_stack_with_search dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  record_stack_checker checker_i (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .fail_count  (fail_count),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Mostly random ids, with a fair share of both extremes
  function automatic logic [ID_W-1:0] rand_id();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return ID_MAX;
      default: return ID_W'($urandom);
    endcase
  endfunction

  function automatic logic [PRICE_W-1:0] rand_price();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return PRICE_MAX;
      default: return PRICE_W'($urandom);
    endcase
  endfunction

  // Op mix: pushes outweigh pops so the stack builds up between clears
  function automatic logic [OP_W-1:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 34) return OP_PUSH;
    if (r < 48) return OP_POP;
    if (r < 58) return OP_PEEK;
    if (r < 76) return OP_SEARCH;
    if (r < 81) return OP_CLEAR;
    if (r < 93) return OP_TOTALS;
    if (r < 97) return OP_SPARE_LO;
    return OP_SPARE_HI;
  endfunction

  function automatic logic [ID_W-1:0] pick_key();
    if ($urandom_range(0, 3) != 0) return key_pool[2'($urandom_range(0, 3))];
    return rand_id();
  endfunction

  // Offer one transaction and hold it until the block takes it. Random gaps
  // go in front unless the sender is in its steady stretch.
  task automatic send_cmd(input logic [OP_W-1:0] op, input logic [ID_W-1:0] key,
                          input logic [ID_W-1:0] pass, input logic [ID_W-1:0] train,
                          input logic [PRICE_W-1:0] price);
    if (!steady_in) begin
      while ($urandom_range(0, 99) < 33) begin
        in_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.ticket_key   <= key;
    in_ch.passenger_in <= pass;
    in_ch.train_in     <= train;
    in_ch.price_in     <= price;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic send_random();
    send_cmd(pick_op(), pick_key(), rand_id(), rand_id(), rand_price());
  endtask

  // Drop valid and wait for every expected result to come back
  task automatic drain_results();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Receiver: random stalls, one long hold-off on request, one steady stretch
  initial begin
    int hold_left;
    int rx_cycle;
    bit hold_taken;
    hold_left    = 0;
    rx_cycle     = 0;
    hold_taken   = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      rx_cycle++;
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else if (rx_cycle >= 1500 && rx_cycle < 2100) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= 33);
      end
    end
  end

  // Watchdog: give up after a generous number of cycles
  initial begin
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    rst_n              = 1'b0;
    steady_in          = 1'b0;
    hold_req           = 1'b0;
    rand_sent          = 0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_PUSH;
    in_ch.ticket_key   = '0;
    in_ch.passenger_in = '0;
    in_ch.train_in     = '0;
    in_ch.price_in     = '0;
    key_pool[0] = ID_MAX;
    key_pool[1] = '0;
    key_pool[2] = ID_W'($urandom);
    key_pool[3] = ID_W'($urandom);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Every reading op on an empty stack reports empty
    send_cmd(OP_POP,    '0,     '0, '0, '0);
    send_cmd(OP_PEEK,   ID_MAX, ID_MAX, ID_MAX, PRICE_MAX);
    send_cmd(OP_SEARCH, ID_MAX, '0, '0, '0);
    send_cmd(OP_TOTALS, '0,     '0, '0, '0);

    // Field extremes; two top prices carry the sum past 32 bits
    send_cmd(OP_PUSH, '0,     '0,     '0,     '0);
    send_cmd(OP_PUSH, ID_MAX, ID_MAX, ID_MAX, PRICE_MAX);
    send_cmd(OP_PUSH, '0,     31'h2AAAAAAA, 31'h55555555, PRICE_MAX);
    send_cmd(OP_PUSH, 31'h55555555, 31'h55555555, 31'h2AAAAAAA, 32'h0000_0001);
    send_cmd(OP_PEEK, rand_id(), rand_id(), rand_id(), rand_price());

    // Search with two hits, one hit and no hit
    send_cmd(OP_SEARCH, '0,       rand_id(), rand_id(), rand_price());
    send_cmd(OP_SEARCH, ID_MAX,   rand_id(), rand_id(), rand_price());
    send_cmd(OP_SEARCH, 31'd12345, '0, '0, '0);
    send_cmd(OP_TOTALS, rand_id(), rand_id(), rand_id(), rand_price());
    send_cmd(OP_POP,    rand_id(), rand_id(), rand_id(), rand_price());
    send_cmd(OP_PEEK,   '0, '0, '0, '0);

    // Unused codes leave the stack alone
    send_cmd(OP_SPARE_LO, rand_id(), rand_id(), rand_id(), rand_price());
    send_cmd(OP_SPARE_HI, ID_MAX, ID_MAX, ID_MAX, PRICE_MAX);

    // Clear empties the stack but the serial keeps counting
    send_cmd(OP_CLEAR,  rand_id(), rand_id(), rand_id(), rand_price());
    send_cmd(OP_TOTALS, '0, '0, '0, '0);
    send_cmd(OP_SEARCH, '0, '0, '0, '0);
    send_cmd(OP_POP,    '0, '0, '0, '0);
    send_cmd(OP_PUSH,   rand_id(), rand_id(), rand_id(), rand_price());
    send_cmd(OP_TOTALS, rand_id(), rand_id(), rand_id(), rand_price());

    // Sender pauses until the block has answered everything
    drain_results();

    while (rand_sent < RANDOM_ITEMS) begin
      steady_in = (rand_sent >= 170 && rand_sent < 220);
      if (rand_sent == FILL_AT) begin
        // Fill the stack past its limit while the receiver holds off, so the
        // block backs up and stalls its input; then search the full stack.
        hold_req <= 1'b1;
        send_cmd(OP_CLEAR, rand_id(), rand_id(), rand_id(), rand_price());
        repeat (STACK_DEPTH + 2) begin
          send_cmd(OP_PUSH, key_pool[2'($urandom_range(0, 3))], rand_id(), rand_id(),
                   rand_price());
        end
        foreach (key_pool[k]) begin
          send_cmd(OP_SEARCH, key_pool[k], rand_id(), rand_id(), rand_price());
        end
        send_cmd(OP_SEARCH, rand_id(), rand_id(), rand_id(), rand_price());
        send_cmd(OP_TOTALS, rand_id(), rand_id(), rand_id(), rand_price());
        send_cmd(OP_PEEK,   rand_id(), rand_id(), rand_id(), rand_price());
        send_cmd(OP_POP,    rand_id(), rand_id(), rand_id(), rand_price());
        send_cmd(OP_PUSH,   key_pool[0], rand_id(), rand_id(), rand_price());
        rand_sent += STACK_DEPTH + 12;
        drain_results();
      end else begin
        send_random();
        rand_sent++;
      end
    end

    // Let the block settle, then give the verdict
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
